/* rtl/fixed_unit_pool_allocator_macros.svh */
// ---------------------------------------------------------------------------
// fixed unit pool allocator assertion macros
// shared concurrent assertion forms for the allocator blocks
// ---------------------------------------------------------------------------
`ifndef FIXED_UNIT_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_UNIT_POOL_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled while reset is applied
`define FUPA_ASSERT_IMPL(LABEL, CLK, RSTN, ANTE, CONS, MSG) \
    LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
        else $error(MSG);

// next-cycle implication, disabled while reset is applied
`define FUPA_ASSERT_NEXT(LABEL, CLK, RSTN, ANTE, CONS, MSG) \
    LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
        else $error(MSG);

`endif

/* rtl/fupa_pkg.sv */
// ---------------------------------------------------------------------------
// fupa_pkg
// types, codes and widths shared by the fixed unit pool allocator
// ---------------------------------------------------------------------------
`default_nettype none

package fupa_pkg;

    // default pool geometry
    localparam int DEFAULT_NUM_UNITS    = 64;
    localparam int DEFAULT_HEADER_BYTES = 16;

    // field widths
    localparam int CMD_W        = 1;
    localparam int REQ_SIZE_W   = 32;
    localparam int ADDR_W       = 32;
    localparam int STATUS_W     = 3;
    localparam int UNIT_INDEX_W = 6;
    localparam int UNIT_SIZE_W  = 16;
    localparam int STRIDE_W     = 17;
    localparam int ALU_W        = 34;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE = 2'd1;
    localparam logic [UNIT_SIZE_W-1:0] UNIT_SIZE_RESET = 16'd64;
    localparam logic [ADDR_W-1:0]      POOL_BASE_RESET = 32'd0;

    // request commands
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_GRANT          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ALLOC_FALLBACK = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RELEASE        = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FREE_FALLBACK  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DROPPED        = 3'd4;

    // request payload
    typedef struct packed {
        logic                  cmd;
        logic [REQ_SIZE_W-1:0] request_size;
        logic                  use_pool;
        logic [ADDR_W-1:0]     release_addr;
    } req_t;

    // result payload
    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [ADDR_W-1:0]       address;
        logic [UNIT_INDEX_W-1:0] unit_index;
    } rsp_t;

    // shared adder operation
    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_op_t;

    // free stack control and status
    typedef struct packed {
        logic pop;
        logic push;
    } stk_ctl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } stk_sts_t;

endpackage

`default_nettype wire

/* rtl/fupa_ifs.sv */
// ---------------------------------------------------------------------------
// fupa channel interfaces
// valid/ready channels for allocator requests and results
// ---------------------------------------------------------------------------
`default_nettype none

interface fupa_req_if;
    logic                             valid;
    logic                             ready;
    logic                             cmd;
    logic [fupa_pkg::REQ_SIZE_W-1:0]  request_size;
    logic                             use_pool;
    logic [fupa_pkg::ADDR_W-1:0]      release_addr;

    modport source (output valid, output cmd, output request_size,
                    output use_pool, output release_addr, input ready);
    modport sink   (input valid, input cmd, input request_size,
                    input use_pool, input release_addr, output ready);
endinterface

interface fupa_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [fupa_pkg::STATUS_W-1:0]     status;
    logic [fupa_pkg::ADDR_W-1:0]       address;
    logic [fupa_pkg::UNIT_INDEX_W-1:0] unit_index;

    modport source (output valid, output status, output address,
                    output unit_index, input ready);
    modport sink   (input valid, input status, input address,
                    input unit_index, output ready);
endinterface

`default_nettype wire

/* rtl/fupa_alu.sv */
// ---------------------------------------------------------------------------
// fupa_alu
// shared add/subtract unit used for every compare, offset and division step
// ---------------------------------------------------------------------------
`default_nettype none

module fupa_alu (
    input  fupa_pkg::alu_op_t           op,
    output logic [fupa_pkg::ALU_W-1:0]  sum
);

    logic [fupa_pkg::ALU_W-1:0] b_eff;

    // subtract is add of the inverted operand plus one; msb is the borrow
    always_comb
    begin
        b_eff = op.sub ? ~op.b : op.b;
        sum   = op.a + b_eff + fupa_pkg::ALU_W'(op.sub);
    end

endmodule

`default_nettype wire

/* rtl/fupa_stack.sv */
// ---------------------------------------------------------------------------
// fupa_stack
// lifo of free unit indices in a memory, with fill count and low watermark
// ---------------------------------------------------------------------------
`default_nettype none

`include "fixed_unit_pool_allocator_macros.svh"

module fupa_stack #(
    parameter int NUM_UNITS = fupa_pkg::DEFAULT_NUM_UNITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fupa_pkg::stk_ctl_t            ctl,
    input  logic [$clog2(NUM_UNITS)-1:0]  wdata,
    output fupa_pkg::stk_sts_t            sts,
    output logic [$clog2(NUM_UNITS)-1:0]  rd_data
);

    localparam int IDX_W = $clog2(NUM_UNITS);
    localparam int CNT_W = $clog2(NUM_UNITS + 1);

    logic [IDX_W-1:0] mem [NUM_UNITS];
    logic [IDX_W-1:0] mem_q;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] wm_reg, wm_next;
    logic             fresh_reg, fresh_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0] rd_slot;
    logic             at_wm;

    // slots below the lowest fill ever reached were never written and hold
    // their own index; a pop that sets a new low reads that implied value
    always_comb
    begin
        rd_slot    = count_reg - CNT_W'(1);
        at_wm      = (count_reg == wm_reg);
        count_next = count_reg;
        wm_next    = wm_reg;
        fresh_next = fresh_reg;
        slot_next  = slot_reg;
        if (ctl.pop)
        begin
            count_next = rd_slot;
            fresh_next = at_wm;
            slot_next  = rd_slot[IDX_W-1:0];
            if (at_wm)
            begin
                wm_next = rd_slot;
            end
        end
        else if (ctl.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    // fill count and watermark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_W'(NUM_UNITS);
            wm_reg    <= CNT_W'(NUM_UNITS);
            fresh_reg <= 1'b0;
            slot_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            wm_reg    <= wm_next;
            fresh_reg <= fresh_next;
            slot_reg  <= slot_next;
        end
    end

    // index memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[count_reg[IDX_W-1:0]] <= wdata;
        end
        if (ctl.pop)
        begin
            mem_q <= mem[rd_slot[IDX_W-1:0]];
        end
    end

    assign rd_data   = fresh_reg ? slot_reg : mem_q;
    assign sts.empty = (count_reg == '0);
    assign sts.full  = (count_reg == CNT_W'(NUM_UNITS));

    // checks
    `FUPA_ASSERT_IMPL(a_no_pop_empty, clk, rst_n, ctl.pop, count_reg != '0, "pop from empty free stack")
    `FUPA_ASSERT_IMPL(a_no_push_full, clk, rst_n, ctl.push, count_reg != CNT_W'(NUM_UNITS), "push to full free stack")
    `FUPA_ASSERT_IMPL(a_wm_below_count, clk, rst_n, 1'b1, wm_reg <= count_reg, "watermark above fill count")
    `FUPA_ASSERT_NEXT(a_pop_dec, clk, rst_n, ctl.pop, count_reg == $past(count_reg) - CNT_W'(1), "pop did not lower count")

endmodule

`default_nettype wire

/* rtl/fupa_ctrl.sv */
// ---------------------------------------------------------------------------
// fupa_ctrl
// sequencer that drives the shared adder through allocate and release steps
// ---------------------------------------------------------------------------
`default_nettype none

`include "fixed_unit_pool_allocator_macros.svh"

module fupa_ctrl #(
    parameter int NUM_UNITS    = fupa_pkg::DEFAULT_NUM_UNITS,
    parameter int HEADER_BYTES = fupa_pkg::DEFAULT_HEADER_BYTES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  fupa_pkg::req_t                      req,
    input  logic [fupa_pkg::UNIT_SIZE_W-1:0]    unit_size,
    input  logic [fupa_pkg::ADDR_W-1:0]         pool_base,
    output fupa_pkg::alu_op_t                   alu_op,
    input  logic [fupa_pkg::ALU_W-1:0]          alu_sum,
    output fupa_pkg::stk_ctl_t                  stk_ctl,
    input  fupa_pkg::stk_sts_t                  stk_sts,
    input  logic [$clog2(NUM_UNITS)-1:0]        stk_rd_data,
    output logic [$clog2(NUM_UNITS)-1:0]        stk_wdata,
    output logic                                res_valid,
    output fupa_pkg::rsp_t                      res,
    input  logic                                res_take
);

    localparam int IDX_W   = $clog2(NUM_UNITS);
    localparam int CNT_W   = $clog2(NUM_UNITS + 1);
    localparam int KW      = $clog2(IDX_W + 1);
    localparam int SPAN_W  = fupa_pkg::STRIDE_W + CNT_W;
    localparam int DVS_W   = fupa_pkg::STRIDE_W + IDX_W - 1;
    localparam int PROD_W  = fupa_pkg::STRIDE_W + IDX_W;
    localparam int AW      = fupa_pkg::ADDR_W;
    localparam int ALU_W   = fupa_pkg::ALU_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_RANGE,
        S_HDR,
        S_DIV,
        S_PUSH,
        S_MUL,
        S_ADD1,
        S_ADD2,
        S_DONE
    } state_t;

    state_t                  state_reg, state_next;
    fupa_pkg::req_t          req_reg, req_next;
    logic [AW-1:0]           off_reg, off_next;
    logic                    gt_reg, gt_next;
    logic [SPAN_W-1:0]       span_reg, span_next;
    logic [AW-1:0]           rem_reg, rem_next;
    logic [DVS_W-1:0]        dvs_reg, dvs_next;
    logic [IDX_W-1:0]        quo_reg, quo_next;
    logic [KW-1:0]           k_reg, k_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [AW-1:0]           acc_reg, acc_next;
    fupa_pkg::rsp_t          res_reg, res_next;

    logic [fupa_pkg::STRIDE_W-1:0] stride;
    logic                          borrow;
    logic                          alloc_fb;
    logic                          ge;

    assign stride = fupa_pkg::STRIDE_W'(unit_size) + fupa_pkg::STRIDE_W'(HEADER_BYTES);
    assign borrow = alu_sum[ALU_W-1];

    // shared adder operand selection
    always_comb
    begin
        alu_op = '0;
        unique case (state_reg)
            S_EVAL:
            begin
                alu_op.sub = 1'b1;
                if (req_reg.cmd == fupa_pkg::CMD_ALLOC)
                begin
                    alu_op.a = ALU_W'(unit_size);
                    alu_op.b = ALU_W'(req_reg.request_size);
                end
                else
                begin
                    alu_op.a = ALU_W'(req_reg.release_addr);
                    alu_op.b = ALU_W'(pool_base);
                end
            end
            S_RANGE:
            begin
                alu_op.sub = 1'b1;
                alu_op.a   = ALU_W'(off_reg);
                alu_op.b   = ALU_W'(span_reg);
            end
            S_HDR:
            begin
                alu_op.sub = 1'b1;
                alu_op.a   = ALU_W'(off_reg);
                alu_op.b   = ALU_W'(HEADER_BYTES);
            end
            S_DIV:
            begin
                alu_op.sub = 1'b1;
                alu_op.a   = ALU_W'(rem_reg);
                alu_op.b   = ALU_W'(dvs_reg);
            end
            S_ADD1:
            begin
                alu_op.a = ALU_W'(pool_base);
                alu_op.b = ALU_W'(prod_reg);
            end
            S_ADD2:
            begin
                alu_op.a = ALU_W'(acc_reg);
                alu_op.b = ALU_W'(HEADER_BYTES);
            end
            default:
            begin
                alu_op = '0;
            end
        endcase
    end

    // sequencer and datapath next values
    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        off_next   = off_reg;
        gt_next    = gt_reg;
        span_next  = span_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        quo_next   = quo_reg;
        k_next     = k_reg;
        idx_next   = idx_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        stk_ctl    = '0;
        alloc_fb   = borrow || !req_reg.use_pool || stk_sts.empty;
        ge         = !borrow;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (req_reg.cmd == fupa_pkg::CMD_ALLOC)
                begin
                    if (alloc_fb)
                    begin
                        res_next   = '{status: fupa_pkg::ST_ALLOC_FALLBACK,
                                       address: '0, unit_index: '0};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        stk_ctl.pop = 1'b1;
                        state_next  = S_MUL;
                    end
                end
                else
                begin
                    // offset from pool base, strictly above it
                    off_next   = alu_sum[AW-1:0];
                    gt_next    = !borrow && (alu_sum[AW-1:0] != '0);
                    span_next  = SPAN_W'(NUM_UNITS) * SPAN_W'(stride);
                    state_next = S_RANGE;
                end
            end
            S_RANGE:
            begin
                if (!(gt_reg && borrow))
                begin
                    res_next   = '{status: fupa_pkg::ST_FREE_FALLBACK,
                                   address: '0, unit_index: '0};
                    state_next = S_DONE;
                end
                else if (stk_sts.full)
                begin
                    res_next   = '{status: fupa_pkg::ST_DROPPED,
                                   address: '0, unit_index: '0};
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_HDR;
                end
            end
            S_HDR:
            begin
                // address inside the first header maps to unit zero
                rem_next   = borrow ? '0 : alu_sum[AW-1:0];
                dvs_next   = DVS_W'(stride) << (IDX_W - 1);
                quo_next   = '0;
                k_next     = KW'(IDX_W - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // one restoring division step per cycle
                if (ge)
                begin
                    rem_next = alu_sum[AW-1:0];
                end
                quo_next = IDX_W'(quo_reg << 1) | IDX_W'(ge);
                dvs_next = dvs_reg >> 1;
                if (k_reg == '0)
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    k_next = k_reg - KW'(1);
                end
            end
            S_PUSH:
            begin
                stk_ctl.push = 1'b1;
                res_next     = '{status: fupa_pkg::ST_RELEASE, address: '0,
                                 unit_index: fupa_pkg::UNIT_INDEX_W'(quo_reg)};
                state_next   = S_DONE;
            end
            S_MUL:
            begin
                idx_next   = stk_rd_data;
                prod_next  = PROD_W'(stk_rd_data) * PROD_W'(stride);
                state_next = S_ADD1;
            end
            S_ADD1:
            begin
                acc_next   = alu_sum[AW-1:0];
                state_next = S_ADD2;
            end
            S_ADD2:
            begin
                res_next   = '{status: fupa_pkg::ST_GRANT, address: alu_sum[AW-1:0],
                               unit_index: fupa_pkg::UNIT_INDEX_W'(idx_reg)};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            req_reg   <= '0;
            off_reg   <= '0;
            gt_reg    <= 1'b0;
            span_reg  <= '0;
            rem_reg   <= '0;
            dvs_reg   <= '0;
            quo_reg   <= '0;
            k_reg     <= '0;
            idx_reg   <= '0;
            prod_reg  <= '0;
            acc_reg   <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            req_reg   <= req_next;
            off_reg   <= off_next;
            gt_reg    <= gt_next;
            span_reg  <= span_next;
            rem_reg   <= rem_next;
            dvs_reg   <= dvs_next;
            quo_reg   <= quo_next;
            k_reg     <= k_next;
            idx_reg   <= idx_next;
            prod_reg  <= prod_next;
            acc_reg   <= acc_next;
            res_reg   <= res_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;
    assign stk_wdata = quo_reg;

    // checks
    `FUPA_ASSERT_IMPL(a_release_status, clk, rst_n, res_valid && req_reg.cmd == fupa_pkg::CMD_RELEASE, res_reg.status != fupa_pkg::ST_GRANT && res_reg.status != fupa_pkg::ST_ALLOC_FALLBACK, "release produced allocate status")
    `FUPA_ASSERT_IMPL(a_div_done, clk, rst_n, state_reg == S_PUSH, k_reg == '0, "push before division finished")

endmodule

`default_nettype wire

/* rtl/fixed_unit_pool_allocator.sv */
// ---------------------------------------------------------------------------
// fixed_unit_pool_allocator
// Hands out and takes back equal-size units of a memory pool kept as a
// lifo of free unit indices, highest index on top after reset. One request
// is worked at a time; a single shared add/subtract unit does every compare,
// offset and address add under a small sequencer, and the free list lives
// in a one-port-write, registered-read memory with no clearing pass (a low
// watermark stands in for the reset contents). A pushed release runs a
// stride division that retires one quotient bit per cycle through the
// shared adder. A finished result sits in the output register, so the next
// request is taken while it waits. Configuration is to be written only
// while no request is open.
// ---------------------------------------------------------------------------
`default_nettype none

module fixed_unit_pool_allocator #(
    parameter int NUM_UNITS    = fupa_pkg::DEFAULT_NUM_UNITS,
    parameter int HEADER_BYTES = fupa_pkg::DEFAULT_HEADER_BYTES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    fupa_req_if.sink                            req,
    fupa_rsp_if.source                          rsp,
    input  logic                                cfg_we,
    input  logic [fupa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fupa_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int IDX_W = $clog2(NUM_UNITS);

    logic [fupa_pkg::UNIT_SIZE_W-1:0] unit_size_reg, unit_size_next;
    logic [fupa_pkg::ADDR_W-1:0]      pool_base_reg, pool_base_next;
    logic                             rsp_valid_reg, rsp_valid_next;
    fupa_pkg::rsp_t                   rsp_data_reg, rsp_data_next;

    fupa_pkg::req_t                   req_data;
    fupa_pkg::alu_op_t                alu_op;
    logic [fupa_pkg::ALU_W-1:0]       alu_sum;
    fupa_pkg::stk_ctl_t               stk_ctl;
    fupa_pkg::stk_sts_t               stk_sts;
    logic [IDX_W-1:0]                 stk_rd_data;
    logic [IDX_W-1:0]                 stk_wdata;
    logic                             res_valid;
    fupa_pkg::rsp_t                   res;
    logic                             res_take;
    logic                             out_free;

    assign req_data = '{cmd: req.cmd, request_size: req.request_size,
                        use_pool: req.use_pool, release_addr: req.release_addr};

    // configuration register decode
    always_comb
    begin
        unit_size_next = unit_size_reg;
        pool_base_next = pool_base_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                fupa_pkg::REG_UNIT_SIZE: unit_size_next = cfg_data[fupa_pkg::UNIT_SIZE_W-1:0];
                fupa_pkg::REG_POOL_BASE: pool_base_next = cfg_data[fupa_pkg::ADDR_W-1:0];
                default:
                begin
                    unit_size_next = unit_size_reg;
                    pool_base_next = pool_base_reg;
                end
            endcase
        end
    end

    // output register between sequencer and result channel
    always_comb
    begin
        out_free       = !rsp_valid_reg || rsp.ready;
        res_take       = res_valid && out_free;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        if (res_take)
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = res;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_size_reg <= fupa_pkg::UNIT_SIZE_RESET;
            pool_base_reg <= fupa_pkg::POOL_BASE_RESET;
            rsp_valid_reg <= 1'b0;
            rsp_data_reg  <= '0;
        end
        else
        begin
            unit_size_reg <= unit_size_next;
            pool_base_reg <= pool_base_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_data_reg  <= rsp_data_next;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = rsp_data_reg.status;
    assign rsp.address    = rsp_data_reg.address;
    assign rsp.unit_index = rsp_data_reg.unit_index;

    // shared adder
    fupa_alu u_alu (
        .op  (alu_op),
        .sum (alu_sum)
    );

    // free index stack
    fupa_stack #(
        .NUM_UNITS (NUM_UNITS)
    ) u_stack (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (stk_ctl),
        .wdata   (stk_wdata),
        .sts     (stk_sts),
        .rd_data (stk_rd_data)
    );

    // sequencer
    fupa_ctrl #(
        .NUM_UNITS    (NUM_UNITS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_ready   (req.ready),
        .req         (req_data),
        .unit_size   (unit_size_reg),
        .pool_base   (pool_base_reg),
        .alu_op      (alu_op),
        .alu_sum     (alu_sum),
        .stk_ctl     (stk_ctl),
        .stk_sts     (stk_sts),
        .stk_rd_data (stk_rd_data),
        .stk_wdata   (stk_wdata),
        .res_valid   (res_valid),
        .res         (res),
        .res_take    (res_take)
    );

endmodule

`default_nettype wire
